// ===== src/sppm_pkg.sv =====
// Shared types and constants of the send page pool manager.
package sppm_pkg;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [1:0] CFG_PAGE_BYTES    = 2'd0;
    localparam logic [1:0] CFG_HEADER_BYTES  = 2'd1;
    localparam logic [1:0] CFG_FLUSH_TIMEOUT = 2'd2;

    localparam logic [30:0] PAGE_BYTES_RST    = 31'd65536;
    localparam logic [6:0]  HEADER_BYTES_RST  = 7'd16;
    localparam logic [31:0] FLUSH_TIMEOUT_RST = 32'd5;
    localparam logic [30:0] CAP_LIMIT         = 31'h4000_0000;

    localparam logic MODE_PUSH   = 1'b0;
    localparam logic MODE_SWITCH = 1'b1;

    typedef struct packed {
        logic [30:0] used;
        logic [29:0] msgs;
        logic        drain;
        logic [31:0] last;
    } t_page;

    typedef struct packed {
        logic load;
        logic rd;
        logic eval;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic hit;
    } t_sts;

endpackage

// ===== src/sppm_ctrl.sv =====
// Controller of the send page pool manager: scan sequencing and handshakes.
module sppm_ctrl
    import sppm_pkg::*;
#(
    parameter int PAGES = 4,
    localparam int IW = $clog2(PAGES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_mode,
    input  logic [1:0]    i_start_page,
    input  logic          i_out_ready,
    input  t_sts          i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_addr
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    start_wrap;
    logic          last;

    // Fold the start page into range for page counts below four.
    always_comb begin
        start_wrap = 8'(i_start_page);
        if (start_wrap >= 8'(PAGES)) begin
            start_wrap = start_wrap - 8'(PAGES);
        end
    end

    assign last = (r_cnt == IW'(PAGES - 1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = (i_mode == MODE_SWITCH) ? '0 : start_wrap[IW-1:0];
                    n_cnt      = '0;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (((i_sts.mode == MODE_PUSH) && i_sts.hit) || last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                    n_cnt   = r_cnt + 1'b1;
                    n_idx   = (r_idx == IW'(PAGES - 1)) ? '0 : r_idx + 1'b1;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_addr      = r_idx;

endmodule

// ===== src/sppm_dp.sv =====
// Datapath of the send page pool manager: page table, config and result registers.
module sppm_dp
    import sppm_pkg::*;
#(
    parameter int PAGES = 4,
    localparam int IW = $clog2(PAGES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_addr,
    input  logic          i_mode,
    input  logic [29:0]   i_payload_length,
    input  logic [15:0]   i_msg_type,
    input  logic [31:0]   i_node_id,
    input  logic [31:0]   i_now_seconds,
    output t_sts          o_sts,
    output logic [1:0]    o_status,
    output logic [1:0]    o_page_index,
    output logic [29:0]   o_byte_offset,
    output logic [29:0]   o_message_count,
    output logic [15:0]   o_header_type,
    output logic [31:0]   o_header_node,
    output logic [29:0]   o_header_length
);

    function automatic logic [29:0] sat30(input logic [30:0] v);
        return v[30] ? 30'h3FFF_FFFF : v[29:0];
    endfunction

    logic [30:0] r_page_bytes;
    logic [6:0]  r_header_bytes;
    logic [31:0] r_flush_timeout;

    logic        r_mode;
    logic [30:0] r_need;
    logic [30:0] r_cap;
    logic [30:0] r_half;
    logic [31:0] r_now;
    logic        r_found;

    t_page            mem [PAGES];
    logic [PAGES-1:0] r_valid;
    t_page            r_rd_page;
    logic             r_rd_ok;

    logic [1:0]  r_res_status;
    logic [1:0]  r_res_page;
    logic [29:0] r_res_offset;
    logic [29:0] r_res_count;
    logic [15:0] r_res_type;
    logic [31:0] r_res_node;
    logic [29:0] r_res_length;

    logic [1:0]  r_o_status;
    logic [1:0]  r_o_page;
    logic [29:0] r_o_offset;
    logic [29:0] r_o_count;
    logic [15:0] r_o_type;
    logic [31:0] r_o_node;
    logic [29:0] r_o_length;

    t_page       pg;
    t_page       wr_page;
    logic        wr_en;
    logic        hit;
    logic [30:0] room;
    logic        fit;
    logic [31:0] age;
    logic        drain_ready;
    logic [29:0] msgs_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes    <= PAGE_BYTES_RST;
            r_header_bytes  <= HEADER_BYTES_RST;
            r_flush_timeout <= FLUSH_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAGE_BYTES:    r_page_bytes    <= i_cfg_data[30:0];
                CFG_HEADER_BYTES:  r_header_bytes  <= i_cfg_data[6:0];
                CFG_FLUSH_TIMEOUT: r_flush_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // An entry that was never written reads as an empty writable page.
    assign pg = r_rd_ok ? r_rd_page : '0;

    always_comb begin
        room        = (r_cap > pg.used) ? (r_cap - pg.used) : '0;
        fit         = (room >= r_need);
        age         = r_now - pg.last;
        drain_ready = (pg.used > r_half) || ((age >= r_flush_timeout) && (pg.used != '0));
        msgs_inc    = (pg.msgs == 30'h3FFF_FFFF) ? pg.msgs : pg.msgs + 1'b1;
        hit         = 1'b0;
        wr_page     = pg;
        wr_en       = 1'b0;
        if (r_mode == MODE_PUSH) begin
            hit          = !pg.drain && fit;
            wr_page.used = pg.used + r_need;
            wr_page.msgs = msgs_inc;
            wr_en        = i_cmd.eval && hit;
        end else if (pg.drain) begin
            // Recycle a drained page.
            wr_page.used  = '0;
            wr_page.msgs  = '0;
            wr_page.drain = 1'b0;
            wr_page.last  = r_now;
            wr_en         = i_cmd.eval;
        end else begin
            hit           = !r_found && drain_ready;
            wr_page.drain = 1'b1;
            wr_en         = i_cmd.eval && hit;
        end
    end

    assign o_sts.mode = r_mode;
    assign o_sts.hit  = hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_page <= mem[i_addr];
            r_rd_ok   <= r_valid[i_addr];
        end
        if (wr_en) begin
            mem[i_addr] <= wr_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_need       <= 31'(r_header_bytes) + 31'(i_payload_length);
            r_cap        <= (r_page_bytes > CAP_LIMIT) ? CAP_LIMIT : r_page_bytes;
            r_half       <= ((r_page_bytes > CAP_LIMIT) ? CAP_LIMIT : r_page_bytes) >> 1;
            r_now        <= i_now_seconds;
            r_found      <= 1'b0;
            r_res_status <= (i_mode == MODE_SWITCH) ? ST_NONE : ST_NO_ROOM;
            r_res_page   <= '0;
            r_res_offset <= '0;
            r_res_count  <= '0;
            r_res_type   <= (i_mode == MODE_SWITCH) ? '0 : i_msg_type;
            r_res_node   <= (i_mode == MODE_SWITCH) ? '0 : i_node_id;
            r_res_length <= (i_mode == MODE_SWITCH) ? '0 : i_payload_length;
        end else if (i_cmd.eval && hit) begin
            r_found      <= 1'b1;
            r_res_status <= (r_mode == MODE_SWITCH) ? ST_DRAIN : ST_PLACED;
            r_res_page   <= 2'(i_addr);
            r_res_offset <= sat30(pg.used);
            r_res_count  <= (r_mode == MODE_SWITCH) ? pg.msgs : msgs_inc;
        end
        if (i_cmd.publish) begin
            r_o_status <= r_res_status;
            r_o_page   <= r_res_page;
            r_o_offset <= r_res_offset;
            r_o_count  <= r_res_count;
            r_o_type   <= r_res_type;
            r_o_node   <= r_res_node;
            r_o_length <= r_res_length;
        end
    end

    assign o_status        = r_o_status;
    assign o_page_index    = r_o_page;
    assign o_byte_offset   = r_o_offset;
    assign o_message_count = r_o_count;
    assign o_header_type   = r_o_type;
    assign o_header_node   = r_o_node;
    assign o_header_length = r_o_length;

endmodule

// ===== src/send_page_pool_manager.sv =====
// Top level of the send page pool manager.
//
// Usage: one input channel (i_in_valid / o_in_ready) carries a beat holding
// either a push (place a message of header_bytes + payload_length bytes in a
// page, scanning cyclically from the start page) or a switch (recycle all
// draining pages, then mark the first page from page 0 that is over half
// full or non-empty and timed out). Every input beat yields exactly one
// result beat on the output channel (o_out_valid / i_out_ready).
// Configuration is a plain write port: i_cfg_we, i_cfg_index, i_cfg_data;
// write it only while no item is in flight.
// Scan: the page table has one read port, so each page is read and then
// evaluated. A push stops at the first page that takes the message; a
// switch always visits all pages. The result is registered into the output
// register from the done state once that register is free.
// Reset (synchronous, active low) empties every page, makes all pages
// writable, restores the register defaults and drops any pending result.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile, and its scan holds at the end until the register frees.
module send_page_pool_manager
    import sppm_pkg::*;
#(
    parameter int PAGES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [1:0]  i_start_page,
    input  logic [29:0] i_payload_length,
    input  logic [15:0] i_msg_type,
    input  logic [31:0] i_node_id,
    input  logic [31:0] i_now_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [1:0]  o_page_index,
    output logic [29:0] o_byte_offset,
    output logic [29:0] o_message_count,
    output logic [15:0] o_header_type,
    output logic [31:0] o_header_node,
    output logic [29:0] o_header_length
);

    localparam int IW = $clog2(PAGES);

    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] addr;

    // Sequence the scan: one page index per read/evaluate pair.
    sppm_ctrl #(
        .PAGES(PAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_start_page(i_start_page),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    // Hold the page table, registers and the result beat.
    sppm_dp #(
        .PAGES(PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .i_mode          (i_mode),
        .i_payload_length(i_payload_length),
        .i_msg_type      (i_msg_type),
        .i_node_id       (i_node_id),
        .i_now_seconds   (i_now_seconds),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_page_index    (o_page_index),
        .o_byte_offset   (o_byte_offset),
        .o_message_count (o_message_count),
        .o_header_type   (o_header_type),
        .o_header_node   (o_header_node),
        .o_header_length (o_header_length)
    );

endmodule

// ===== src/sppm_checker.sv =====
// Port-level checks of the send page pool manager, bound to the top level.
module sppm_checker
    import sppm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [1:0]  o_page_index,
    input logic [29:0] o_byte_offset,
    input logic [29:0] o_message_count,
    input logic [15:0] o_header_type,
    input logic [31:0] o_header_node,
    input logic [29:0] o_header_length
);

    // Result beat holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result beat dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_placed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_PLACED) |-> (o_message_count != '0))
        else $error("placed message left page count at zero");

    a_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NO_ROOM) |->
            (o_page_index == '0) && (o_byte_offset == '0) && (o_message_count == '0))
        else $error("failed push reports a page");

    a_switch_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_DRAIN) || (o_status == ST_NONE)) |->
            (o_header_type == '0) && (o_header_node == '0) && (o_header_length == '0))
        else $error("switch result carries header fields");

endmodule

bind send_page_pool_manager sppm_checker u_sppm_checker (.*);

// ===== tb/send_page_pool_manager_checker.sv =====
// Scoreboard for the send page pool manager: mirrors the page table and checks each result beat.
`timescale 1ns / 100ps

module send_page_pool_manager_checker
    import sppm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [1:0]  i_start_page,
    input  logic [29:0] i_payload_length,
    input  logic [15:0] i_msg_type,
    input  logic [31:0] i_node_id,
    input  logic [31:0] i_now_seconds,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [1:0]  i_page_index,
    input  logic [29:0] i_byte_offset,
    input  logic [29:0] i_message_count,
    input  logic [15:0] i_header_type,
    input  logic [31:0] i_header_node,
    input  logic [29:0] i_header_length,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NUM_PAGES = 4;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  page;
        logic [29:0] offset;
        logic [29:0] count;
        logic [15:0] htype;
        logic [31:0] hnode;
        logic [29:0] hlen;
    } t_pool_outcome;

    logic [30:0] cfg_page_bytes;
    logic [6:0]  cfg_header_bytes;
    logic [31:0] cfg_flush_timeout;

    logic [30:0] page_fill     [NUM_PAGES];
    logic [29:0] page_msgs     [NUM_PAGES];
    logic        page_drain    [NUM_PAGES];
    logic [31:0] page_flush_at [NUM_PAGES];

    t_pool_outcome outcomes_due[$];
    int mismatches = 0;
    int outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    function automatic logic [29:0] clamp30(logic [30:0] v);
        return (v > 31'h3FFF_FFFF) ? 30'h3FFF_FFFF : v[29:0];
    endfunction

    // Apply one push or switch to the mirrored page table and return its result.
    function automatic t_pool_outcome apply_pool_op(logic mode, logic [1:0] start,
                                                    logic [29:0] len, logic [15:0] mtype,
                                                    logic [31:0] node, logic [31:0] now);
        t_pool_outcome r;
        logic [31:0] cap;
        logic [31:0] need;
        logic [31:0] room;
        logic [31:0] age;
        logic [1:0]  idx;
        bit          found;
        r = '0;
        found = 1'b0;
        cap = (cfg_page_bytes > CAP_LIMIT) ? {1'b0, CAP_LIMIT} : {1'b0, cfg_page_bytes};
        if (mode == MODE_PUSH) begin
            need = {25'd0, cfg_header_bytes} + {2'd0, len};
            r.status = ST_NO_ROOM;
            r.htype  = mtype;
            r.hnode  = node;
            r.hlen   = len;
            idx = start;
            for (int k = 0; k < NUM_PAGES; k++) begin
                room = (cap > {1'b0, page_fill[idx]}) ? cap - {1'b0, page_fill[idx]} : 32'd0;
                if (!found && !page_drain[idx] && room >= need) begin
                    r.status = ST_PLACED;
                    r.page   = idx;
                    r.offset = clamp30(page_fill[idx]);
                    page_fill[idx] = page_fill[idx] + need[30:0];
                    if (page_msgs[idx] != 30'h3FFF_FFFF) page_msgs[idx]++;
                    r.count = page_msgs[idx];
                    found = 1'b1;
                end
                idx = idx + 2'd1;
            end
        end else begin
            // recycle drained pages first, then pick the first page worth draining
            for (int k = 0; k < NUM_PAGES; k++) begin
                if (page_drain[k]) begin
                    page_fill[k]     = '0;
                    page_msgs[k]     = '0;
                    page_flush_at[k] = now;
                    page_drain[k]    = 1'b0;
                end
            end
            r.status = ST_NONE;
            for (int k = 0; k < NUM_PAGES; k++) begin
                age = now - page_flush_at[k];
                if (!found && ({1'b0, page_fill[k]} > (cap >> 1) ||
                               (age >= cfg_flush_timeout && page_fill[k] != '0))) begin
                    page_drain[k] = 1'b1;
                    r.status = ST_DRAIN;
                    r.page   = 2'(k);
                    r.offset = clamp30(page_fill[k]);
                    r.count  = page_msgs[k];
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pool_outcome want;
        if (!i_rst_n) begin
            cfg_page_bytes    = PAGE_BYTES_RST;
            cfg_header_bytes  = HEADER_BYTES_RST;
            cfg_flush_timeout = FLUSH_TIMEOUT_RST;
            for (int k = 0; k < NUM_PAGES; k++) begin
                page_fill[k]     = '0;
                page_msgs[k]     = '0;
                page_drain[k]    = 1'b0;
                page_flush_at[k] = '0;
            end
            outcomes_due.delete();
            outstanding = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAGE_BYTES:    cfg_page_bytes    = i_cfg_data[30:0];
                    CFG_HEADER_BYTES:  cfg_header_bytes  = i_cfg_data[6:0];
                    CFG_FLUSH_TIMEOUT: cfg_flush_timeout = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (outcomes_due.size() == 0) begin
                    $error("result beat with no item outstanding");
                    mismatches++;
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status",        want.status, i_status);
                    check_field("page_index",    want.page,   i_page_index);
                    check_field("byte_offset",   want.offset, i_byte_offset);
                    check_field("message_count", want.count,  i_message_count);
                    check_field("header_type",   want.htype,  i_header_type);
                    check_field("header_node",   want.hnode,  i_header_node);
                    check_field("header_length", want.hlen,   i_header_length);
                end
            end
            if (i_in_valid && i_in_ready)
                outcomes_due.push_back(apply_pool_op(i_mode, i_start_page, i_payload_length,
                                                     i_msg_type, i_node_id, i_now_seconds));
            outstanding = outcomes_due.size();
        end
    end

endmodule

// ===== tb/send_page_pool_manager_tb.sv =====
// Top-level testbench of the send page pool manager: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module send_page_pool_manager_tb;
    import sppm_pkg::*;

    // Generous run limit: ~850 beats plus stalls fit many times over.
    localparam int CYCLE_LIMIT   = 200000;
    // A switch scans every page before its result reaches the output register.
    localparam int SETTLE_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_mode;
    logic [1:0]  i_start_page;
    logic [29:0] i_payload_length;
    logic [15:0] i_msg_type;
    logic [31:0] i_node_id;
    logic [31:0] i_now_seconds;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [1:0]  o_page_index;
    logic [29:0] o_byte_offset;
    logic [29:0] o_message_count;
    logic [15:0] o_header_type;
    logic [31:0] o_header_node;
    logic [29:0] o_header_length;

    int              fail_count;
    int              pending;
    int              cycle_count = 0;
    bit              gaps_on = 1'b1;
    longint unsigned cur_page_bytes;
    longint unsigned cur_header;
    logic [31:0]     cur_now;

    send_page_pool_manager dut (.*);

    send_page_pool_manager_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_start_page     (i_start_page),
        .i_payload_length (i_payload_length),
        .i_msg_type       (i_msg_type),
        .i_node_id        (i_node_id),
        .i_now_seconds    (i_now_seconds),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_page_index     (o_page_index),
        .i_byte_offset    (o_byte_offset),
        .i_message_count  (o_message_count),
        .i_header_type    (o_header_type),
        .i_header_node    (o_header_node),
        .i_header_length  (o_header_length),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall about 19 percent of the time unless gaps are switched off.
    always @(negedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(99) >= 19);
    end

    // Present one beat at a falling edge, with random idle cycles ahead of it, and
    // hold it until the block takes it. Valid stays high across back-to-back beats.
    task automatic send_op(input logic mode, input logic [1:0] start, input logic [29:0] len,
                           input logic [15:0] mtype, input logic [31:0] node,
                           input logic [31:0] now);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= mode;
        i_start_page     <= start;
        i_payload_length <= len;
        i_msg_type       <= mtype;
        i_node_id        <= node;
        i_now_seconds    <= now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and hold off until every result beat is back and the block is quiet.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all three registers; only call while drained. Unused upper data bits get junk,
    // which the block must ignore.
    task automatic configure(input logic [30:0] pb, input logic [6:0] hb,
                             input logic [31:0] tmo);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PAGE_BYTES;
        i_cfg_data  <= ($urandom & 32'h8000_0000) | {1'b0, pb};
        @(negedge i_clk);
        i_cfg_index <= CFG_HEADER_BYTES;
        i_cfg_data  <= ($urandom & 32'hFFFF_FF80) | {25'd0, hb};
        @(negedge i_clk);
        i_cfg_index <= CFG_FLUSH_TIMEOUT;
        i_cfg_data  <= tmo;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_page_bytes = pb;
        cur_header     = hb;
    endtask

    // Random traffic sized to the current page capacity so pages actually fill,
    // overflow into neighbors and get drained, with some oversized noise mixed in.
    task automatic random_phase(input int count, input int hold_at);
        logic            mode;
        logic [29:0]     len;
        longint unsigned cap;
        int unsigned     pick;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) drain_results();
            cap  = (cur_page_bytes > 64'h4000_0000) ? 64'h4000_0000 : cur_page_bytes;
            pick = $urandom_range(99);
            if (pick < 10)
                len = '0;
            else if (pick < 16)
                len = 30'($urandom);
            else if (pick < 26)
                len = (cap > cur_header + 8) ? 30'(cap - cur_header - $urandom_range(8)) : '0;
            else
                len = 30'($urandom_range(32'(cap / 5 + 1)));
            // Mostly creep the clock forward; sometimes jump far so ages wrap.
            pick = $urandom_range(99);
            if (pick < 80)
                cur_now = cur_now + $urandom_range(2);
            else if (pick < 95)
                cur_now = cur_now + $urandom_range(12);
            else
                cur_now = $urandom;
            mode = ($urandom_range(99) < 22) ? MODE_SWITCH : MODE_PUSH;
            send_op(mode, 2'($urandom), len, 16'($urandom), $urandom, cur_now);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_PAGE_BYTES;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_mode           = MODE_PUSH;
        i_start_page     = '0;
        i_payload_length = '0;
        i_msg_type       = '0;
        i_node_id        = '0;
        i_now_seconds    = '0;
        cur_page_bytes   = PAGE_BYTES_RST;
        cur_header       = HEADER_BYTES_RST;
        cur_now          = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on reset defaults: 64 KiB pages, 16-byte header, 5 s timeout.
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd0);             // empty pool: none ready
        send_op(MODE_PUSH, 2'd3, '0, '0, '0, 32'd0);               // zero payload, last page
        send_op(MODE_PUSH, 2'd0, 30'h3FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0); // no room
        send_op(MODE_PUSH, 2'd1, 30'd65520, 16'hA5A5, 32'h1234_5678, 32'd0); // page 1 exact fill
        send_op(MODE_PUSH, 2'd1, 30'd1, 16'h5A5A, 32'h8765_4321, 32'd0);     // spill to page 2
        send_op(MODE_SWITCH, 2'd2, '0, '0, '0, 32'd1);             // page 1 over half: drain
        send_op(MODE_PUSH, 2'd1, 30'd10, 16'd7, 32'd9, 32'd1);     // skip the draining page
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd2);             // recycle page 1, none ready
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'hFFFF_FFFF);     // aged page 2 drains
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd3);             // recycle, none ready
        drain_results();

        // Zero capacity with zero timeout: nothing fits, any non-empty page drains.
        configure(31'd0, 7'd64, 32'd0);
        send_op(MODE_PUSH, 2'd2, '0, 16'd1, 32'd2, 32'd4);
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd4);
        drain_results();

        // Capacity above the 1 GiB bound, minimal header, maximal timeout.
        configure(31'h7FFF_FFFF, 7'd1, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 2'd0, 30'h3FFF_FFFF, 16'd3, 32'd4, 32'd5); // fills a page to 1 GiB
        send_op(MODE_PUSH, 2'd0, '0, 16'd5, 32'd6, 32'd5);
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd5);   // saturated byte offset
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd6);
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd1);   // age wraps to the maximum
        drain_results();

        // One-byte pages with a 64-byte header: no message fits.
        configure(31'd1, 7'd64, 32'd5);
        send_op(MODE_PUSH, 2'd1, '0, 16'd8, 32'd9, 32'd7);
        send_op(MODE_SWITCH, 2'd0, '0, '0, '0, 32'd8);
        drain_results();

        // Random phases; shrinking the capacity under filled pages is intentional.
        configure(31'd4096, 7'd16, 32'd5);
        random_phase(140, 70);       // pause mid-phase until every result is back
        drain_results();
        configure(31'd1, 7'd1, 32'd0);
        random_phase(100, -1);
        drain_results();
        configure(31'h4000_0000, 7'd64, 32'hFFFF_FFFF);
        random_phase(150, -1);
        drain_results();
        configure(31'h7FFF_FFFF, 7'd33, 32'd3);
        random_phase(140, -1);
        drain_results();
        configure(31'd300, 7'd7, 32'd2);
        gaps_on = 1'b0;              // long stretch at full rate on both sides
        random_phase(160, -1);
        drain_results();
        gaps_on = 1'b1;
        configure(31'd65536, 7'd16, 32'd5);
        random_phase(160, 80);
        drain_results();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sppm_pkg.sv
src/sppm_ctrl.sv
src/sppm_dp.sv
src/send_page_pool_manager.sv
src/sppm_checker.sv
tb/send_page_pool_manager_checker.sv
tb/send_page_pool_manager_tb.sv
